/* sv/tgq_pkg.sv */
// Package for the tick-grouped, id-ordered queue.
// Holds the command and status codes, controller states and fixed field widths.
// No dependencies.
`default_nettype none

package tgq_pkg;

  localparam int FUNC_W   = 2;
  localparam int PORT_ID_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQUEUE = 2'd0,
    FN_DEQUEUE = 2'd1,
    FN_TICK    = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL_DROP = 2'd1,
    STS_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_PLACE,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

/* sv/tgq_if.sv */
// Valid/ready channel interfaces for the queue: command items in, result items out.
// Depends on tgq_pkg for field widths.
`default_nettype none

interface tgq_in_if import tgq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [PORT_ID_W-1:0] new_id;

  modport source (output valid, output func, output new_id, input ready);
  modport sink   (input valid, input func, input new_id, output ready);
endinterface

interface tgq_out_if import tgq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [PORT_ID_W-1:0] popped_id;
  logic [COUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output popped_id, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input popped_id, input entry_count,
                  output ready);
endinterface

`default_nettype wire

/* sv/tgq_id_ram.sv */
// Id store of the queue: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module tgq_id_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/tick_grouped_id_ordered_queue_unit.sv */
// Top level of the tick-grouped, id-ordered queue: controller, pointers, result register.
// Depends on tgq_pkg, tgq_in_if / tgq_out_if and tgq_id_ram.
//
//   channel   | dir | handshake      | payload
//   ----------+-----+----------------+-------------------------------------
//   in_ch     | in  | valid / ready  | func[1:0], new_id[15:0]
//   out_ch    | out | valid / ready  | status[1:0], popped_id[15:0],
//             |     |                | entry_count[6:0]
//
// Steps: one item at a time. Tick, plain append, drop on full and empty
// dequeue go straight to emit; a dequeue passes a pop step (one read of the
// id memory); a sorted insert walks the fresh entries back from the foot and
// moves those not below the id one slot back, one entry a cycle, then writes the id.
// Reset: synchronous, active low; clears the state, pointers, counts and the
// output valid flag. The result payload and the id memory are not cleared.
// Stalls: a finished result waits in the result register; the controller
// holds in its emit step until the output slot frees, then takes new items.
`default_nettype none

module tick_grouped_id_ordered_queue_unit import tgq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tgq_in_if.sink    in_ch,
  tgq_out_if.source out_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // The queue is a ring in memory: head_r is the oldest entry, tail_r the
  // next free slot. Fresh entries always form the tail end of the ring, so
  // a count of them replaces per-entry marks and a tick just zeroes it.
  state_t             state_r, state_nxt;
  logic [AW-1:0]      head_r, tail_r;
  logic [CW-1:0]      count_r, fresh_r;
  logic [ID_BITS-1:0] foot_id_r;   // id of the last entry
  logic [AW-1:0]      ptr_r;       // slot under the insert walk
  logic [CW-1:0]      left_r;      // fresh entries still to examine
  logic [ID_BITS-1:0] key_r;       // id being inserted

  status_t              res_status_r;
  logic [PORT_ID_W-1:0] res_pop_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [PORT_ID_W-1:0] out_pop_r;
  logic [COUNT_W-1:0]   out_count_r;

  // memory port
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ID_BITS-1:0] mem_wdata, mem_rdata;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  logic               in_ready;
  logic               accept;
  logic               slot_free;
  logic [ID_BITS-1:0] id_in;
  logic               is_full, is_empty;
  logic               go_insert;
  logic [AW-1:0]      foot_ptr;
  logic               shift_back;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_ch.valid && in_ready;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign id_in      = ID_BITS'(in_ch.new_id);
  assign is_full    = (count_r == CW'(QUEUE_DEPTH));
  assign is_empty   = (count_r == '0);
  assign foot_ptr   = ptr_dec(tail_r);
  // Insert inside the fresh group only when the foot is fresh and above the id.
  assign go_insert  = (fresh_r != '0) && (foot_id_r > id_in);
  // Move an entry back while it is not below the key.
  assign shift_back = (mem_rdata >= key_r);

  tgq_id_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EMIT;
          if (in_ch.func == FN_ENQUEUE && !is_full && go_insert) begin
            state_nxt = S_SCAN;
          end else if (in_ch.func == FN_DEQUEUE && !is_empty) begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP:   state_nxt = S_EMIT;
      S_SCAN: begin
        if (!shift_back) begin
          state_nxt = S_EMIT;
        end else if (left_r == CW'(1)) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = id_in;
    mem_re    = 1'b0;
    mem_raddr = head_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.func == FN_ENQUEUE && !is_full) begin
          if (go_insert) begin
            mem_re    = 1'b1;
            mem_raddr = foot_ptr;
          end else begin
            mem_we    = 1'b1;
          end
        end else if (accept && in_ch.func == FN_DEQUEUE && !is_empty) begin
          mem_re = 1'b1;
        end
      end
      S_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc(ptr_r);
        mem_wdata = shift_back ? mem_rdata : key_r;
        mem_re    = shift_back && (left_r != CW'(1));
        mem_raddr = ptr_dec(ptr_r);
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = key_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        unique case (func_t'(in_ch.func))
          FN_ENQUEUE: begin
            if (!is_full) begin
              tail_r  <= ptr_inc(tail_r);
              count_r <= count_r + 1'b1;
              fresh_r <= fresh_r + 1'b1;
            end
          end
          FN_DEQUEUE: begin
            if (!is_empty) begin
              head_r  <= ptr_inc(head_r);
              count_r <= count_r - 1'b1;
              // drop a fresh entry only when every entry is fresh
              if (fresh_r == count_r) begin
                fresh_r <= fresh_r - 1'b1;
              end
            end
          end
          FN_TICK: fresh_r <= '0;
          default: begin
          end
        endcase
      end
      if (state_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r        <= id_in;
      ptr_r        <= foot_ptr;
      left_r       <= fresh_r;
      res_status_r <= STS_OK;
      res_pop_r    <= '0;
      if (in_ch.func == FN_ENQUEUE) begin
        if (is_full) begin
          res_status_r <= STS_FULL_DROP;
        end else if (!go_insert) begin
          foot_id_r <= id_in;
        end
      end else if (in_ch.func == FN_DEQUEUE && is_empty) begin
        res_status_r <= STS_EMPTY;
      end
    end
    if (state_r == S_POP) begin
      res_pop_r <= PORT_ID_W'(mem_rdata);
    end
    if (state_r == S_SCAN && shift_back && left_r != CW'(1)) begin
      ptr_r  <= ptr_dec(ptr_r);
      left_r <= left_r - 1'b1;
    end
    if (state_r == S_EMIT && slot_free) begin
      out_status_r <= res_status_r;
      out_pop_r    <= res_pop_r;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.popped_id   = out_pop_r;
  assign out_ch.entry_count = out_count_r;

endmodule

`default_nettype wire

/* sv/tgq_checker.sv */
// Port-level checks on the queue's result channel, bound to the top level.
// Depends on tgq_pkg for status codes and widths.
`default_nettype none

module tgq_checker import tgq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [STATUS_W-1:0]  out_status,
  input wire logic [PORT_ID_W-1:0] out_popped_id,
  input wire logic [COUNT_W-1:0]   out_entry_count
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_popped_id) && $stable(out_entry_count))
    else $error("result item changed while stalled");

  // A dropped enqueue only happens on a full queue.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_FULL_DROP |->
      out_entry_count == COUNT_W'(QUEUE_DEPTH))
    else $error("drop reported on a queue that is not full");

  // An empty dequeue leaves the queue empty and pops nothing.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_EMPTY |->
      out_entry_count == '0 && out_popped_id == '0)
    else $error("empty dequeue with entries or a popped id");

  // A nonzero popped id comes with an ok status.
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_popped_id != '0 |-> out_status == STS_OK)
    else $error("popped id on a failed item");

endmodule

bind tick_grouped_id_ordered_queue_unit tgq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tgq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_popped_id   (out_ch.popped_id),
  .out_entry_count (out_ch.entry_count)
);

`default_nettype wire
